// ===== hw/rtl/rlc_pkg.sv =====
// Package for the reference-counted LRU cache.
// Holds command and status codes and fixed field widths; no dependencies.
package rlc_pkg;

  localparam int KEY_W    = 64;
  localparam int HASH_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int CHARGE_W = 16;
  localparam int DELTA_W  = 17;
  localparam int HANDLE_W = 5;
  localparam int CAP_W    = 24;
  localparam int USAGE_W  = 21;
  localparam int REFS_W   = 16;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FREED = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_RELEASE    = 3'd2,
    CMD_ERASE      = 3'd3,
    CMD_PRUNE      = 3'd4,
    CMD_SET_CHARGE = 3'd5,
    CMD_ADD_CHARGE = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISS    = 3'd1,
    ST_NO_SLOT = 3'd2,
    ST_BAD_HDL = 3'd3,
    ST_LIMIT   = 3'd4
  } status_e;

endpackage

// ===== hw/rtl/refcounted_lru_cache_top.sv =====
// Reference-counted LRU cache: sequencer, slot bookkeeping and result output.
// Depends on rlc_pkg and rlc_slot_mem.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o; a request is taken when valid is
//   high and stall is low. Results leave on out_valid_o / out_stall_i, one per
//   freed slot (kind 1) and then one reply (kind 0, last 1).
//   Capacity is written on cfg_valid_i / cfg_ready_o; ready is high only while
//   the block is idle.
//   One request at a time: stall stays high from acceptance until the reply
//   has been taken.
//   Steps: a dispatch state; for lookup, erase and insert with caching on, a key
//   search over the slot store, one slot per cycle, and a decision state; a
//   shrink check and an uncache step per eviction, one step per erased entry or
//   freed reference; then for each freed-slot result an output check, a slot
//   read, a show and a wait state, and for the reply an output check, a show and
//   a wait state, plus any output stall. A lookup miss searches every slot.
//   The receiver may stall a result for any time; the result holds.
//   Reset empties the cache, clears usage and sets capacity to 65536.
module refcounted_lru_cache_top import rlc_pkg::*; #(
  parameter int ENTRIES  = 32,
  parameter int KEY_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [HASH_W-1:0]    hash_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic [CHARGE_W-1:0]  charge_i,
  input  logic signed [DELTA_W-1:0] delta_i,
  input  logic [HANDLE_W-1:0]  handle_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 kind_o,
  output logic [2:0]           status_o,
  output logic [HANDLE_W-1:0]  slot_o,
  output logic [KEY_W-1:0]     key_out_o,
  output logic [VALUE_W-1:0]   value_out_o,
  output logic [USAGE_W-1:0]   usage_now_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CAP_W-1:0]     cfg_data_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam int UW = IW + CHARGE_W;
  localparam int CW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [IW:0] NIL = (IW+1)'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_FOUND, S_INS, S_UNC, S_DROP, S_SHRINK,
    S_PRUNE, S_OUT, S_EVRD, S_EVSH, S_EVWT, S_REPLY, S_RWT
  } state_e;

  state_e              state_q, ret_q;
  cmd_e                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [HASH_W-1:0]   hash_q;
  logic [VALUE_W-1:0]  value_q;
  logic [CHARGE_W-1:0] charge_q;
  logic [DELTA_W-1:0]  delta_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CAP_W-1:0]    capacity_q;

  logic                used_q   [ENTRIES];
  logic                cached_q [ENTRIES];
  logic [REFS_W-1:0]   refs_q   [ENTRIES];
  logic [CHARGE_W-1:0] chg_q    [ENTRIES];
  logic [IW:0]         nxt_q    [ENTRIES];
  logic [IW:0]         prv_q    [ENTRIES];
  logic [IW:0]         head_q, tail_q;
  logic [UW-1:0]       usage_q;

  logic [IW-1:0]       free_q, sidx_q, tgt_q, pidx_q;
  logic                found_q, pend_q;
  logic [IW:0]         cnt_q;
  logic [VALUE_W-1:0]  sval_q;
  status_e             st_q;
  logic [IW-1:0]       rslot_q;
  logic [VALUE_W-1:0]  rval_q;
  logic [IW-1:0]       evq_q [ENTRIES];
  logic [IW:0]         ewp_q, erp_q;

  logic                out_valid_q, kind_q, last_q;
  logic [2:0]          status_q;
  logic [HANDLE_W-1:0] slot_q;
  logic [KEY_W-1:0]    okey_q;
  logic [VALUE_W-1:0]  oval_q;
  logic [USAGE_W-1:0]  ousage_q;

  logic [IW-1:0]       raddr;
  logic [KEY_BITS-1:0] rkey;
  logic [HASH_W-1:0]   rhash;
  logic [VALUE_W-1:0]  rvalue;
  logic                free_ok;
  logic [IW-1:0]       free_idx;
  logic [IW-1:0]       hd_idx;
  logic                hd_ok;
  logic [CHARGE_W+1:0] nc;
  logic                match;
  logic [REFS_W-1:0]   tref_dec;
  logic [IW:0]         t_p, t_n;
  logic                cap_on;

  // search and event reads share the one read port
  assign raddr = (state_q == S_SRCH) ? cnt_q[IW-1:0] : evq_q[erp_q[IW-1:0]];

  rlc_slot_mem #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == S_INS),
    .waddr_i (free_q),
    .wkey_i  (key_q),
    .whash_i (hash_q),
    .wvalue_i(value_q),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rhash_o (rhash),
    .rvalue_o(rvalue)
  );

  // lowest unused slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // per-request helpers
  always_comb begin
    hd_idx   = IW'(handle_q);
    hd_ok    = (32'(handle_q) < 32'(ENTRIES)) && used_q[hd_idx];
    nc       = {2'b00, chg_q[hd_idx]} + {delta_q[DELTA_W-1], delta_q};
    match    = pend_q && used_q[pidx_q] && cached_q[pidx_q] &&
               (rkey == key_q) && (rhash == hash_q);
    tref_dec = refs_q[tgt_q] - 1'b1;
    t_p      = prv_q[tgt_q];
    t_n      = nxt_q[tgt_q];
    cap_on   = (capacity_q != '0);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // sequencer, slot bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cmd_q       <= CMD_LOOKUP;
      key_q       <= '0;
      hash_q      <= '0;
      value_q     <= '0;
      charge_q    <= '0;
      delta_q     <= '0;
      handle_q    <= '0;
      capacity_q  <= CAP_W'(65536);
      for (int i = 0; i < ENTRIES; i++) begin
        used_q[i]   <= 1'b0;
        cached_q[i] <= 1'b0;
        refs_q[i]   <= '0;
        chg_q[i]    <= '0;
        nxt_q[i]    <= '0;
        prv_q[i]    <= '0;
        evq_q[i]    <= '0;
      end
      head_q      <= NIL;
      tail_q      <= NIL;
      usage_q     <= '0;
      free_q      <= '0;
      sidx_q      <= '0;
      tgt_q       <= '0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      sval_q      <= '0;
      st_q        <= ST_OK;
      rslot_q     <= '0;
      rval_q      <= '0;
      ewp_q       <= '0;
      erp_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_REPLY;
      last_q      <= 1'b0;
      status_q    <= '0;
      slot_q      <= '0;
      okey_q      <= '0;
      oval_q      <= '0;
      ousage_q    <= '0;
    end else begin
      // take a capacity write
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= cmd_e'(cmd_i);
            key_q    <= key_i[KEY_BITS-1:0];
            hash_q   <= hash_i;
            value_q  <= value_i;
            charge_q <= charge_i;
            delta_q  <= delta_i;
            handle_q <= handle_i;
            st_q     <= ST_OK;
            rslot_q  <= '0;
            rval_q   <= '0;
            ewp_q    <= '0;
            erp_q    <= '0;
            found_q  <= 1'b0;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            state_q  <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd_q)
            CMD_LOOKUP, CMD_ERASE: state_q <= S_SRCH;
            CMD_INSERT: begin
              if (!free_ok) begin
                st_q    <= ST_NO_SLOT;
                state_q <= S_OUT;
              end else begin
                free_q  <= free_idx;
                state_q <= cap_on ? S_SRCH : S_INS;
              end
            end
            CMD_RELEASE: begin
              if (!hd_ok || (cached_q[hd_idx] && refs_q[hd_idx] <= REFS_W'(1))) begin
                st_q    <= ST_BAD_HDL;
                state_q <= S_OUT;
              end else begin
                tgt_q   <= hd_idx;
                ret_q   <= S_OUT;
                state_q <= S_DROP;
              end
            end
            CMD_PRUNE: state_q <= S_PRUNE;
            CMD_SET_CHARGE: begin
              if (!hd_ok) begin
                st_q <= ST_BAD_HDL;
              end else begin
                if (cached_q[hd_idx]) begin
                  usage_q <= usage_q - UW'(chg_q[hd_idx]) + UW'(charge_q);
                end
                chg_q[hd_idx] <= charge_q;
              end
              state_q <= S_OUT;
            end
            CMD_ADD_CHARGE: begin
              if (!hd_ok) begin
                st_q <= ST_BAD_HDL;
              end else if (nc[CHARGE_W+1] || nc[CHARGE_W]) begin
                st_q <= ST_LIMIT;
              end else begin
                if (cached_q[hd_idx]) begin
                  usage_q <= usage_q - UW'(chg_q[hd_idx]) + UW'(nc[CHARGE_W-1:0]);
                end
                chg_q[hd_idx] <= nc[CHARGE_W-1:0];
              end
              state_q <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_SRCH: begin
          // issue one slot read a cycle, compare the one read before
          pend_q <= (cnt_q < (IW+1)'(ENTRIES));
          pidx_q <= cnt_q[IW-1:0];
          if (cnt_q < (IW+1)'(ENTRIES)) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (match) begin
            found_q <= 1'b1;
            sidx_q  <= pidx_q;
            sval_q  <= rvalue;
            state_q <= S_FOUND;
          end else if (!pend_q && cnt_q == (IW+1)'(ENTRIES)) begin
            found_q <= 1'b0;
            state_q <= S_FOUND;
          end
        end
        S_FOUND: begin
          case (cmd_q)
            CMD_LOOKUP: begin
              if (!found_q) begin
                st_q <= ST_MISS;
              end else if (refs_q[sidx_q] >= REFS_MAX) begin
                st_q <= ST_LIMIT;
              end else begin
                if (refs_q[sidx_q] == REFS_W'(1)) begin
                  if (prv_q[sidx_q] == NIL) head_q <= nxt_q[sidx_q];
                  else nxt_q[prv_q[sidx_q][IW-1:0]] <= nxt_q[sidx_q];
                  if (nxt_q[sidx_q] == NIL) tail_q <= prv_q[sidx_q];
                  else prv_q[nxt_q[sidx_q][IW-1:0]] <= prv_q[sidx_q];
                end
                refs_q[sidx_q] <= refs_q[sidx_q] + 1'b1;
                rslot_q <= sidx_q;
                rval_q  <= sval_q;
              end
              state_q <= S_OUT;
            end
            CMD_ERASE: begin
              if (!found_q) begin
                st_q    <= ST_MISS;
                state_q <= S_OUT;
              end else begin
                tgt_q   <= sidx_q;
                ret_q   <= S_OUT;
                state_q <= S_UNC;
              end
            end
            CMD_INSERT: state_q <= S_INS;
            default: state_q <= S_OUT;
          endcase
        end
        S_INS: begin
          // fill the free slot; an old entry with the same key then leaves the cache
          used_q[free_q] <= 1'b1;
          chg_q[free_q]  <= charge_q;
          rslot_q        <= free_q;
          if (cap_on) begin
            refs_q[free_q]   <= REFS_W'(2);
            cached_q[free_q] <= 1'b1;
            usage_q          <= usage_q + UW'(charge_q);
          end else begin
            refs_q[free_q]   <= REFS_W'(1);
            cached_q[free_q] <= 1'b0;
          end
          if (found_q) begin
            tgt_q   <= sidx_q;
            ret_q   <= S_SHRINK;
            state_q <= S_UNC;
          end else begin
            state_q <= S_SHRINK;
          end
        end
        S_UNC: begin
          // drop from cache and give back its reference
          if (refs_q[tgt_q] == REFS_W'(1)) begin
            if (t_p == NIL) head_q <= t_n;
            else nxt_q[t_p[IW-1:0]] <= t_n;
            if (t_n == NIL) tail_q <= t_p;
            else prv_q[t_n[IW-1:0]] <= t_p;
          end
          cached_q[tgt_q] <= 1'b0;
          usage_q         <= usage_q - UW'(chg_q[tgt_q]);
          refs_q[tgt_q]   <= tref_dec;
          if (tref_dec == '0) begin
            used_q[tgt_q]           <= 1'b0;
            evq_q[ewp_q[IW-1:0]]    <= tgt_q;
            ewp_q                   <= ewp_q + 1'b1;
          end
          state_q <= ret_q;
        end
        S_DROP: begin
          // give back one reference; park in LRU order when only the cache holds it
          refs_q[tgt_q] <= tref_dec;
          if (tref_dec == '0) begin
            used_q[tgt_q]        <= 1'b0;
            cached_q[tgt_q]      <= 1'b0;
            evq_q[ewp_q[IW-1:0]] <= tgt_q;
            ewp_q                <= ewp_q + 1'b1;
          end else if (cached_q[tgt_q] && tref_dec == REFS_W'(1)) begin
            nxt_q[tgt_q] <= NIL;
            prv_q[tgt_q] <= tail_q;
            if (tail_q == NIL) head_q <= {1'b0, tgt_q};
            else nxt_q[tail_q[IW-1:0]] <= {1'b0, tgt_q};
            tail_q <= {1'b0, tgt_q};
          end
          state_q <= ret_q;
        end
        S_SHRINK: begin
          if ((CW'(usage_q) > CW'(capacity_q)) && head_q != NIL) begin
            tgt_q   <= head_q[IW-1:0];
            ret_q   <= S_SHRINK;
            state_q <= S_UNC;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_PRUNE: begin
          if (head_q != NIL) begin
            tgt_q   <= head_q[IW-1:0];
            ret_q   <= S_PRUNE;
            state_q <= S_UNC;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: state_q <= (erp_q == ewp_q) ? S_REPLY : S_EVRD;
        S_EVRD: state_q <= S_EVSH;
        S_EVSH: begin
          out_valid_q <= 1'b1;
          kind_q      <= KIND_FREED;
          status_q    <= ST_OK;
          slot_q      <= HANDLE_W'(evq_q[erp_q[IW-1:0]]);
          okey_q      <= KEY_W'(rkey);
          oval_q      <= rvalue;
          ousage_q    <= USAGE_W'(usage_q);
          last_q      <= 1'b0;
          state_q     <= S_EVWT;
        end
        S_EVWT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            erp_q       <= erp_q + 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_REPLY: begin
          out_valid_q <= 1'b1;
          kind_q      <= KIND_REPLY;
          status_q    <= st_q;
          slot_q      <= HANDLE_W'(rslot_q);
          okey_q      <= '0;
          oval_q      <= rval_q;
          ousage_q    <= USAGE_W'(usage_q);
          last_q      <= 1'b1;
          state_q     <= S_RWT;
        end
        S_RWT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign key_out_o   = okey_q;
  assign value_out_o = oval_q;
  assign usage_now_o = ousage_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // no result is shown while a request can be taken
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result valid while idle");

  // a taken reply frees the block for the next request
  a_reply_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !in_stall_o)
    else $error("block not idle after reply");

  // LRU order ends are empty together
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NIL) == (tail_q == NIL))
    else $error("LRU head and tail disagree on empty");

  // event reads never pass the write pointer
  a_evq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    erp_q <= ewp_q)
    else $error("event queue read passed write");
`endif

endmodule

// ===== hw/rtl/rlc_slot_mem.sv =====
// Slot store for key, hash and value words: one write port, one registered read.
// Depends on rlc_pkg for field widths.
module rlc_slot_mem import rlc_pkg::*; #(
  parameter int ENTRIES  = 32,
  parameter int KEY_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [KEY_BITS-1:0]        wkey_i,
  input  logic [HASH_W-1:0]          whash_i,
  input  logic [VALUE_W-1:0]         wvalue_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [KEY_BITS-1:0]        rkey_o,
  output logic [HASH_W-1:0]          rhash_o,
  output logic [VALUE_W-1:0]         rvalue_o
);

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  logic [HASH_W-1:0]   hash_mem  [ENTRIES];
  logic [VALUE_W-1:0]  value_mem [ENTRIES];

  // write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]   <= wkey_i;
      hash_mem[waddr_i]  <= whash_i;
      value_mem[waddr_i] <= wvalue_i;
    end
  end

  // registered read every cycle
  always_ff @(posedge clk_i) begin
    rkey_o   <= key_mem[raddr_i];
    rhash_o  <= hash_mem[raddr_i];
    rvalue_o <= value_mem[raddr_i];
  end

endmodule
